>>> rtl/assert_macros.svh
// Assertion macros shared by the window stack RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant that holds at every edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    `ASSERT_SAME(label, 1'b1, cond, msg)

`endif

>>> rtl/wsht_pkg.sv
// Shared types and constants of the window stack hit-test block.
// No dependencies.
`timescale 1ns / 1ps

package wsht_pkg;

    // Width of the reported window id field
    localparam int ID_OUT_W = 5;

    // Item function codes
    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_CLICK = 1'b1
    } func_t;

endpackage

>>> rtl/wsht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wsht_ram #(
    parameter int WIDTH = 53,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/window_stack_hit_test_top.sv
// Window stack hit test: a z-ordered stack of rectangles held in one RAM.
// Depends on wsht_pkg, wsht_ram and assert_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item:
//   func selects a load (append a rectangle on top) or a click at a point.
//   Output channel (out_valid / out_stall) carries hit and window_id, one
//   transaction per click; loads give no result, and a load beyond
//   MAX_WINDOWS is dropped.
//   Sequence: a load writes its entry on top of the stack. A click scans the
//   stack from the top, one entry per cycle, through the single read port of
//   the window RAM. A hit below the top raises the result, then moves the
//   window to the top: each row above it moves down by one through the RAM,
//   and then the saved entry is written on top. A hit on the top entry needs
//   no move. A miss scans the whole stack (no scan with an empty stack).
//   The result sits in an output register; while the receiver stalls, the
//   scan holds on the deciding entry until the register is free.
//   Reset empties the stack (count to zero) and drops any pending result;
//   the RAM itself is not cleared, since only loaded entries are read.

module window_stack_hit_test_top #(
    parameter int MAX_WINDOWS = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [COORD_BITS-1:0]         point_x,
    input  logic [COORD_BITS-1:0]         point_y,
    input  logic [COORD_BITS-1:0]         far_x,
    input  logic [COORD_BITS-1:0]         far_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [wsht_pkg::ID_OUT_W-1:0] window_id
);

    import wsht_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W   = $clog2(MAX_WINDOWS + 1);
    localparam int IDX_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int ENTRY_W = 4 * COORD_BITS + CNT_W;

    // Entry layout: {id, far_y, far_x, near_y, near_x}
    localparam int NX_LO = 0;
    localparam int NY_LO = COORD_BITS;
    localparam int FX_LO = 2 * COORD_BITS;
    localparam int FY_LO = 3 * COORD_BITS;
    localparam int ID_LO = 4 * COORD_BITS;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_SHIFT,
        S_PLACE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    hit_reg, hit_next;
    logic [ID_OUT_W-1:0]     window_id_reg, window_id_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [COORD_BITS-1:0]   px_reg, px_next;
    logic [COORD_BITS-1:0]   py_reg, py_next;
    logic [ENTRY_W-1:0]      keep_reg, keep_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;

    logic [CNT_W-1:0]        count_m1;
    logic [CNT_W-1:0]        count_p1;
    logic [IDX_W-1:0]        last_idx;
    logic                    out_free;
    logic                    rd_hit;
    logic [COORD_BITS-1:0]   rd_nx, rd_ny, rd_fx, rd_fy;
    logic [CNT_W-1:0]        rd_id;

    // Window table
    wsht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WINDOWS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode the entry read last cycle and test the click point
    assign rd_nx  = ram_rdata[NX_LO +: COORD_BITS];
    assign rd_ny  = ram_rdata[NY_LO +: COORD_BITS];
    assign rd_fx  = ram_rdata[FX_LO +: COORD_BITS];
    assign rd_fy  = ram_rdata[FY_LO +: COORD_BITS];
    assign rd_id  = ram_rdata[ID_LO +: CNT_W];
    assign rd_hit = (rd_nx <= px_reg) && (px_reg <= rd_fx)
                 && (rd_ny <= py_reg) && (py_reg <= rd_fy);

    assign count_m1 = count_reg - CNT_W'(1);
    assign count_p1 = count_reg + CNT_W'(1);
    assign last_idx = count_m1[IDX_W-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: load, scan from the top, shift rows down, place on top
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        keep_next      = keep_reg;
        hit_next       = hit_reg;
        window_id_next = window_id_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        // Append on top unless the stack is full
                        if (count_reg < CNT_W'(MAX_WINDOWS))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = {count_p1, far_y, far_x, point_y, point_x};
                            count_next = count_p1;
                        end
                    end
                    else
                    begin
                        px_next = point_x;
                        py_next = point_y;
                        if (count_reg == '0)
                        begin
                            state_next = S_MISS;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = last_idx;
                            pos_next   = last_idx;
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_MISS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    window_id_next = '0;
                    state_next     = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (rd_hit)
                begin
                    // Report the hit, save the entry, then raise it unless it is already on top
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        hit_next       = 1'b1;
                        window_id_next = ID_OUT_W'(rd_id);
                        keep_next      = ram_rdata;
                        if (pos_reg == last_idx)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pos_reg + IDX_W'(1);
                            pos_next   = pos_reg + IDX_W'(1);
                            state_next = S_SHIFT;
                        end
                    end
                end
                else if (pos_reg == '0)
                begin
                    // Bottom reached without a hit
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        hit_next       = 1'b0;
                        window_id_next = '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_reg - IDX_W'(1);
                    pos_next  = pos_reg - IDX_W'(1);
                end
            end

            S_SHIFT:
            begin
                // Move the row read last cycle down by one
                ram_we    = 1'b1;
                ram_waddr = pos_reg - IDX_W'(1);
                ram_wdata = ram_rdata;
                if (pos_reg == last_idx)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_reg + IDX_W'(1);
                    pos_next  = pos_reg + IDX_W'(1);
                end
            end

            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = last_idx;
                ram_wdata  = keep_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, count and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            window_id_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            window_id_reg <= window_id_next;
        end
    end

    // Hold the click point, scan position and saved entry
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        keep_reg <= keep_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign window_id = window_id_reg;

    // Checks
    `ASSERT_ALWAYS(a_count_max, count_reg <= CNT_W'(MAX_WINDOWS),
        "window count exceeds capacity")
    `ASSERT_SAME(a_scan_in_range, state_reg == S_SCAN || state_reg == S_SHIFT,
        CNT_W'(pos_reg) < count_reg, "table position beyond loaded windows")
    `ASSERT_SAME(a_no_rw_overlap, ram_we && ram_re, ram_waddr != ram_raddr,
        "read and write hit the same table entry")
    `ASSERT_NEXT(a_result_held, out_valid_reg && out_stall,
        out_valid_reg && $stable(hit_reg) && $stable(window_id_reg),
        "stalled result overwritten")

endmodule

>>> dv/tb_window_stack_hit_test_top.sv
// Self-checking testbench for window_stack_hit_test_top: loads and clicks
// are predicted against a z-ordered window stack model kept in a scoreboard.
// Depends on wsht_pkg and the window_stack_hit_test_top RTL.
`timescale 1ns / 1ps

module tb_window_stack_hit_test_top;

    import wsht_pkg::*;

    localparam int MAX_WINDOWS   = 16;
    localparam int COORD_BITS    = 12;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 400000;
    // settle time after the last result, covering the deepest hit and its move
    localparam int DRAIN_CYCLES  = 2 * MAX_WINDOWS + 20;
    localparam int PHASE_ITEMS   = 170;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [ID_OUT_W-1:0]   wid_t;

    typedef struct packed
    {
        coord_t nx;
        coord_t ny;
        coord_t fx;
        coord_t fy;
        wid_t   id;
    } window_rect_t;

    typedef struct packed
    {
        logic hit;
        wid_t id;
    } click_result_t;

    // Window stack predictor and queue of expected click results
    class hit_scoreboard;
        window_rect_t  stack_rows[MAX_WINDOWS];
        int            loaded;
        click_result_t pending_hits[$];
        int            errors;

        function new();
            loaded = 0;
            errors = 0;
        endfunction

        function bit covers(window_rect_t w, coord_t x, coord_t y);
            return w.nx <= x && x <= w.fx && w.ny <= y && y <= w.fy;
        endfunction

        // Apply one accepted transaction to the stack
        function void note_item(func_t f, coord_t x, coord_t y, coord_t fx, coord_t fy);
            click_result_t res;
            window_rect_t  keep;
            int            pos;
            int            k;
            if (f == FUNC_LOAD)
            begin
                // drop loads beyond capacity
                if (loaded < MAX_WINDOWS)
                begin
                    stack_rows[loaded] = '{nx: x, ny: y, fx: fx, fy: fy, id: wid_t'(loaded + 1)};
                    loaded++;
                end
                return;
            end
            res = '0;
            // search from the top down, raise the hit window to the top
            for (pos = loaded - 1; pos >= 0; pos--)
            begin
                if (covers(stack_rows[pos], x, y))
                begin
                    res.hit = 1'b1;
                    res.id  = stack_rows[pos].id;
                    keep    = stack_rows[pos];
                    for (k = pos + 1; k < loaded; k++)
                        stack_rows[k - 1] = stack_rows[k];
                    stack_rows[loaded - 1] = keep;
                    break;
                end
            end
            pending_hits.push_back(res);
        endfunction

        function void compare(click_result_t got);
            click_result_t want;
            if (pending_hits.size() == 0)
            begin
                errors++;
                $error("unexpected result: hit=%0b window_id=%0d", got.hit, got.id);
                return;
            end
            want = pending_hits.pop_front();
            if (got.hit !== want.hit)
            begin
                errors++;
                $error("hit: expected %0b, actual %0b", want.hit, got.hit);
            end
            if (got.id !== want.id)
            begin
                errors++;
                $error("window_id: expected %0d, actual %0d", want.id, got.id);
            end
        endfunction

        // Check one accepted result against the oldest expected one
        function void check_result(logic hit_bit, wid_t id);
            click_result_t got;
            got.hit = hit_bit;
            got.id  = id;
            compare(got);
        endfunction

        function bit idle();
            return pending_hits.size() == 0;
        endfunction

        function void report_leftovers();
            if (!idle())
            begin
                errors++;
                $error("%0d expected results never arrived", pending_hits.size());
            end
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    logic   func;
    coord_t point_x;
    coord_t point_y;
    coord_t far_x;
    coord_t far_y;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   hit;
    wid_t   window_id;

    int     send_idle_pct = 15;
    int     recv_idle_pct = 49;
    int     cycle_count   = 0;

    hit_scoreboard sb = new();

    window_stack_hit_test_top #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_BITS  (COORD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .point_x   (point_x),
        .point_y   (point_y),
        .far_x     (far_x),
        .far_y     (far_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .window_id (window_id)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Watch both channels: note inputs first, then check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(func_t'(func), point_x, point_y, far_x, far_y);
            if (out_valid && !out_stall)
                sb.check_result(hit, window_id);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive one transaction, with a random idle gap ahead of it
    task automatic send_item(func_t f, coord_t x, coord_t y, coord_t fx, coord_t fy);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        point_x  <= x;
        point_y  <= y;
        far_x    <= fx;
        far_y    <= fy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random loads and clicks; most clicks aim inside a loaded window
    task automatic run_random(int items);
        coord_t       x;
        coord_t       y;
        coord_t       fx;
        coord_t       fy;
        window_rect_t w;
        int           span;
        int           hi;
        int           load_pct;
        repeat (items)
        begin
            x  = coord_t'($urandom_range(0, COORD_MAX));
            y  = coord_t'($urandom_range(0, COORD_MAX));
            fx = coord_t'($urandom_range(0, COORD_MAX));
            fy = coord_t'($urandom_range(0, COORD_MAX));
            load_pct = (sb.loaded < MAX_WINDOWS) ? 30 : 8;
            if ($urandom_range(0, 99) < load_pct)
            begin
                // keep fully random corners now and then, which often inverts
                if ($urandom_range(0, 9) != 0)
                begin
                    span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, COORD_MAX)
                                                       : $urandom_range(0, 600);
                    hi = x + span;
                    if (hi > COORD_MAX)
                        hi = COORD_MAX;
                    fx = coord_t'(hi);
                    span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, COORD_MAX)
                                                       : $urandom_range(0, 600);
                    hi = y + span;
                    if (hi > COORD_MAX)
                        hi = COORD_MAX;
                    fy = coord_t'(hi);
                end
                send_item(FUNC_LOAD, x, y, fx, fy);
            end
            else
            begin
                if (sb.loaded != 0 && $urandom_range(0, 3) != 0)
                begin
                    w = sb.stack_rows[$urandom_range(0, sb.loaded - 1)];
                    if (w.nx <= w.fx && w.ny <= w.fy)
                    begin
                        case ($urandom_range(0, 3))
                            0:
                            begin
                                x = w.nx;
                                y = w.ny;
                            end
                            1:
                            begin
                                x = w.fx;
                                y = w.fy;
                            end
                            default:
                            begin
                                x = coord_t'($urandom_range(w.nx, w.fx));
                                y = coord_t'($urandom_range(w.ny, w.fy));
                            end
                        endcase
                    end
                end
                send_item(FUNC_CLICK, x, y, fx, fy);
            end
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        func     <= FUNC_LOAD;
        point_x  <= '0;
        point_y  <= '0;
        far_x    <= '0;
        far_y    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clicks on an empty stack miss
        send_item(FUNC_CLICK, 0, 0, 0, 0);
        send_item(FUNC_CLICK, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        // inclusive bounds, just inside and just outside each edge
        send_item(FUNC_LOAD, 100, 200, 300, 400);
        send_item(FUNC_CLICK, 100, 200, 0, 0);
        send_item(FUNC_CLICK, 300, 400, 0, 0);
        send_item(FUNC_CLICK, 301, 400, 0, 0);
        send_item(FUNC_CLICK, 300, 401, 0, 0);
        send_item(FUNC_CLICK, 99, 300, 0, 0);
        send_item(FUNC_CLICK, 200, 199, 0, 0);
        // inverted rectangles can never be hit
        send_item(FUNC_LOAD, 500, 500, 400, 600);
        send_item(FUNC_CLICK, 450, 550, 0, 0);
        send_item(FUNC_CLICK, 500, 500, 0, 0);
        send_item(FUNC_LOAD, 10, 600, 20, 500);
        send_item(FUNC_CLICK, 15, 550, 0, 0);
        // full-screen window, then overlap and move to front
        send_item(FUNC_LOAD, 0, 0, COORD_MAX, COORD_MAX);
        send_item(FUNC_CLICK, COORD_MAX, COORD_MAX, 0, 0);
        send_item(FUNC_CLICK, 200, 300, 0, 0);
        send_item(FUNC_LOAD, 150, 250, 250, 350);
        send_item(FUNC_CLICK, 200, 300, 0, 0);
        send_item(FUNC_CLICK, 120, 220, 0, 0);
        send_item(FUNC_CLICK, 200, 300, 0, 0);
        // single-pixel window at the origin
        send_item(FUNC_LOAD, 0, 0, 0, 0);
        send_item(FUNC_CLICK, 0, 0, COORD_MAX, COORD_MAX);

        run_random(PHASE_ITEMS);
        send_idle_pct = 49;
        recv_idle_pct = 15;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        in_valid <= 1'b0;

        // drain outstanding results, then let the block settle
        while (!sb.idle())
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.report_leftovers();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
